>>> rtl/core/uart_rx_tick_sampler_ring_writer_assert.svh
// Assertion macros for the serial receiver core.
`ifndef UART_RX_TICK_SAMPLER_RING_WRITER_ASSERT_SVH
`define UART_RX_TICK_SAMPLER_RING_WRITER_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define URX_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Condition a implies condition c in the next cycle.
`define URX_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

>>> rtl/core/uartrx_pkg.sv
`default_nettype none

package uartrx_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 500;

  localparam int PHASE_W = 7;
  localparam int SLOT_W  = 4;
  localparam int INDEX_W = 9;
  localparam int DATA_W  = 8;

  localparam logic [PHASE_W-1:0] START_CHECK_PHASE  = 7'd4;
  localparam logic [PHASE_W-1:0] FIRST_SAMPLE_PHASE = 7'd14;
  localparam logic [PHASE_W-1:0] SAMPLE_SPACING     = 7'd10;
  localparam logic [PHASE_W-1:0] STOP_PHASE         = 7'd94;
  localparam logic [SLOT_W-1:0]  DATA_BITS          = 4'd8;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_STORED    = 2'd1,
    EV_START_BAD = 2'd2,
    EV_STOP_BAD  = 2'd3
  } event_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] next_action;
    logic [SLOT_W-1:0]  bit_slot;
    logic [DATA_W-1:0]  bits;
    logic [INDEX_W-1:0] head;
    logic [INDEX_W-1:0] fill;
    logic [INDEX_W-1:0] high_water;
  } rx_state_t;

  typedef struct packed {
    event_t             ev;
    logic [DATA_W-1:0]  data;
    logic [INDEX_W-1:0] write_index;
    logic [INDEX_W-1:0] fill;
    logic [INDEX_W-1:0] high_water;
  } rx_result_t;

endpackage

`default_nettype wire

>>> rtl/core/uartrx_step.sv
`default_nettype none

module uartrx_step #(
  parameter int BUFFER_DEPTH = uartrx_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  uartrx_pkg::rx_state_t              st,
  input  logic                               line_high,
  input  logic [uartrx_pkg::INDEX_W-1:0]     rd,
  output uartrx_pkg::rx_state_t              st_next,
  output uartrx_pkg::rx_result_t             res
);

  localparam int DepthW = $clog2(BUFFER_DEPTH + 1);
  localparam int SumW   = ((DepthW > uartrx_pkg::INDEX_W) ? DepthW : uartrx_pkg::INDEX_W) + 1;

  logic [uartrx_pkg::PHASE_W-1:0] ph;
  logic [uartrx_pkg::INDEX_W-1:0] head_inc;
  logic [uartrx_pkg::INDEX_W-1:0] head_new;
  logic [SumW-1:0]                h_wide;
  logic [SumW-1:0]                r_wide;
  logic [SumW-1:0]                f_wide;
  logic [uartrx_pkg::INDEX_W-1:0] fill_new;
  logic [uartrx_pkg::DATA_W-1:0]  keep;

  assign ph       = st.phase + 7'd1;
  assign head_inc = st.head + 9'd1;
  assign head_new = (SumW'(head_inc) == SumW'(BUFFER_DEPTH)) ? '0 : head_inc;
  assign h_wide   = SumW'(head_new);
  assign r_wide   = SumW'(rd);
  assign f_wide   = (h_wide >= r_wide) ? (h_wide - r_wide)
                                       : (h_wide + SumW'(BUFFER_DEPTH) - r_wide);
  assign fill_new = f_wide[uartrx_pkg::INDEX_W-1:0];

  // Bits at or above the slot count read as zero.
  always_comb begin
    for (int i = 0; i < uartrx_pkg::DATA_W; i++) begin
      keep[i] = (st.bit_slot > uartrx_pkg::SLOT_W'(i));
    end
  end

  always_comb begin
    st_next         = st;
    res.ev          = uartrx_pkg::EV_NONE;
    res.data        = '0;
    res.write_index = '0;

    if (st.phase == '0) begin
      if (!line_high) begin
        st_next.phase       = 7'd1;
        st_next.next_action = uartrx_pkg::START_CHECK_PHASE;
        st_next.bit_slot    = '0;
      end
    end else begin
      st_next.phase = ph;
      if (st.next_action > ph) begin
        // wait for the next action phase
      end else if (ph <= uartrx_pkg::START_CHECK_PHASE) begin
        if (line_high) begin
          st_next.phase       = '0;
          st_next.next_action = '0;
          st_next.bit_slot    = '0;
          res.ev              = uartrx_pkg::EV_START_BAD;
        end else begin
          st_next.next_action = uartrx_pkg::FIRST_SAMPLE_PHASE;
          st_next.bits        = '0;
        end
      end else if (ph < uartrx_pkg::STOP_PHASE) begin
        if (st.bit_slot < uartrx_pkg::DATA_BITS) begin
          st_next.bits[st.bit_slot[2:0]] = line_high;
        end
        st_next.bit_slot    = st.bit_slot + 4'd1;
        st_next.next_action = st.next_action + uartrx_pkg::SAMPLE_SPACING;
      end else if (!line_high) begin
        st_next.phase       = '0;
        st_next.next_action = '0;
        st_next.bit_slot    = '0;
        res.ev              = uartrx_pkg::EV_STOP_BAD;
      end else begin
        res.ev              = uartrx_pkg::EV_STORED;
        res.data            = st.bits & keep;
        res.write_index     = st.head;
        st_next.head        = head_new;
        st_next.fill        = fill_new;
        if (fill_new >= st.high_water) begin
          st_next.high_water = fill_new;
        end
        st_next.phase       = '0;
        st_next.next_action = '0;
        st_next.bit_slot    = '0;
      end
    end

    res.fill       = st_next.fill;
    res.high_water = st_next.high_water;
  end

endmodule

`default_nettype wire

>>> rtl/core/uart_rx_tick_sampler_ring_writer.sv
// Oversampled 8N1 serial receiver that feeds an external ring buffer. Each
// item is one tick: a line sample plus the consumer's read index. A low line
// from idle opens a frame; the start bit is rechecked at phase 4, data bits
// are taken LSB first at phases 14, 24 .. 84, and the stop bit is checked at
// phase 94. Every item yields exactly one result item: an event code, the
// byte and its ring slot (both zero unless a byte was stored), the fill after
// the latest store and the high-water mark since reset. The block takes one
// item per cycle while sample_stall is low and returns its result through the
// input register, then the result register; the frame state update is a
// single combinational pass between them. A stall on the result side backs
// up into sample_stall once both registers hold items.
`default_nettype none

`include "uart_rx_tick_sampler_ring_writer_assert.svh"

module uart_rx_tick_sampler_ring_writer #(
  parameter int BUFFER_DEPTH = uartrx_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic                               line_level,
  input  logic [uartrx_pkg::INDEX_W-1:0]     read_index,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [1:0]                         event_code,
  output logic [uartrx_pkg::DATA_W-1:0]      data_byte,
  output logic [uartrx_pkg::INDEX_W-1:0]     write_index,
  output logic [uartrx_pkg::INDEX_W-1:0]     fill_count,
  output logic [uartrx_pkg::INDEX_W-1:0]     high_water
);

  // Input register.
  logic                           s1_valid;
  logic                           s1_line;
  logic [uartrx_pkg::INDEX_W-1:0] s1_read;

  // Frame and ring state.
  uartrx_pkg::rx_state_t  state;
  uartrx_pkg::rx_state_t  state_next;
  uartrx_pkg::rx_result_t step_res;

  logic out_free;
  logic advance;
  logic take;

  // Result register is free when empty or being drained this cycle.
  assign out_free     = !result_valid || !result_stall;
  assign advance      = s1_valid && out_free;
  assign sample_stall = s1_valid && !out_free;
  assign take         = sample_valid && !sample_stall;

  uartrx_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_step (
    .st       (state),
    .line_high(s1_line),
    .rd       (s1_read),
    .st_next  (state_next),
    .res      (step_res)
  );

  // Input register: load on accept, drop when moved on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_line <= line_level;
      s1_read <= read_index;
    end
  end

  // Commit the frame state only when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code  <= step_res.ev;
      data_byte   <= step_res.data;
      write_index <= step_res.write_index;
      fill_count  <= step_res.fill;
      high_water  <= step_res.high_water;
    end
  end

  // The mark never shrinks.
  `URX_ASSERT_NEXT(a_hw_monotonic, clk, rst, 1'b1,
    state.high_water >= $past(state.high_water), "high-water mark dropped")

  // An idle frame carries no pending action or bit count.
  `URX_ASSERT_NOW(a_idle_clean, clk, rst, state.phase == '0,
    state.next_action == '0 && state.bit_slot == '0, "idle frame holds stale state")

  // Only a stored byte carries data and a ring slot.
  `URX_ASSERT_NOW(a_no_store_zero, clk, rst,
    result_valid && event_code != uartrx_pkg::EV_STORED,
    data_byte == '0 && write_index == '0, "payload set without a store")

  // Only a stored byte moves the head.
  `URX_ASSERT_NEXT(a_head_on_store, clk, rst,
    !(advance && step_res.ev == uartrx_pkg::EV_STORED),
    state.head == $past(state.head), "head moved without a store")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH        = uartrx_pkg::DEFAULT_BUFFER_DEPTH;
  localparam int RANDOM_TICKS = 650;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SHOW_LIMIT   = 10;
  // First tick of the data bit window and the tick where the stop bit window starts,
  // so that every sample lands mid-bit.
  localparam int BIT_EDGE     = 9;
  localparam int STOP_EDGE    = 89;

  // Shapes of line activity that one stimulus row expands into.
  typedef enum int {
    FR_IDLE,       // line held high for len ticks
    FR_NOISE,      // random line levels for len ticks
    FR_GOOD,       // full 8N1 frame with a high stop bit
    FR_START_BAD,  // start edge that is gone again at the start check
    FR_STOP_BAD    // full frame with the stop bit low
  } frame_kind_t;

  typedef struct {
    frame_kind_t                    kind;
    logic [uartrx_pkg::DATA_W-1:0]  data;
    logic [uartrx_pkg::INDEX_W-1:0] rd;
    int                             len;
    bit                             pinned;  // expected result of the last tick typed in below
    uartrx_pkg::rx_result_t         pin;
  } frame_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  logic                           line_level = 1'b1;
  logic [uartrx_pkg::INDEX_W-1:0] read_index = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [1:0]                     event_code;
  logic [uartrx_pkg::DATA_W-1:0]  data_byte;
  logic [uartrx_pkg::INDEX_W-1:0] write_index;
  logic [uartrx_pkg::INDEX_W-1:0] fill_count;
  logic [uartrx_pkg::INDEX_W-1:0] high_water;

  // Receiver state as the testbench tracks it, one update per accepted tick.
  uartrx_pkg::rx_state_t  rx_track = '0;
  uartrx_pkg::rx_result_t tick_results_q[$];
  uartrx_pkg::rx_result_t got_want;

  bit  calm = 1'b0;        // no idling on either side while set
  int  stall_left = 0;
  int  cycle_count = 0;
  int  ticks_sent = 0;
  int  directed_ticks = 0;
  int  mismatch_count = 0;
  int  ev_tally[4] = '{0, 0, 0, 0};

  // Directed rows. Rows with pinned set carry a result read straight off the spec:
  // idle after reset, the first stores from an empty ring and the two reject codes.
  // The remaining rows (read index at the top of range and past it) go to the predictor.
  frame_row_t directed_rows [0:7] = '{
    '{FR_IDLE,      8'h00, 9'd0,   3, 1'b1,
      '{uartrx_pkg::EV_NONE,      8'h00, 9'd0, 9'd0, 9'd0}},
    '{FR_GOOD,      8'hA5, 9'd0,   0, 1'b1,
      '{uartrx_pkg::EV_STORED,    8'hA5, 9'd0, 9'd1, 9'd1}},
    '{FR_START_BAD, 8'h00, 9'd0,   0, 1'b1,
      '{uartrx_pkg::EV_START_BAD, 8'h00, 9'd0, 9'd1, 9'd1}},
    '{FR_STOP_BAD,  8'h3C, 9'd0,   0, 1'b1,
      '{uartrx_pkg::EV_STOP_BAD,  8'h00, 9'd0, 9'd1, 9'd1}},
    '{FR_GOOD,      8'h00, 9'd0,   0, 1'b1,
      '{uartrx_pkg::EV_STORED,    8'h00, 9'd1, 9'd2, 9'd2}},
    '{FR_GOOD,      8'hFF, 9'd499, 0, 1'b0,
      '{uartrx_pkg::EV_NONE,      8'h00, 9'd0, 9'd0, 9'd0}},
    '{FR_GOOD,      8'h5A, 9'd511, 0, 1'b0,
      '{uartrx_pkg::EV_NONE,      8'h00, 9'd0, 9'd0, 9'd0}},
    '{FR_IDLE,      8'h00, 9'd511, 4, 1'b0,
      '{uartrx_pkg::EV_NONE,      8'h00, 9'd0, 9'd0, 9'd0}}
  };

  uart_rx_tick_sampler_ring_writer #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .line_level   (line_level),
    .read_index   (read_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_code   (event_code),
    .data_byte    (data_byte),
    .write_index  (write_index),
    .fill_count   (fill_count),
    .high_water   (high_water)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void drop_frame();
    rx_track.phase       = '0;
    rx_track.next_action = '0;
    rx_track.bit_slot    = '0;
  endfunction

  // Advance the tracked receiver by one line tick and return the result item it owes.
  function automatic uartrx_pkg::rx_result_t next_tick_result(
      input logic lvl, input logic [uartrx_pkg::INDEX_W-1:0] rd);
    uartrx_pkg::rx_result_t         res;
    logic [uartrx_pkg::PHASE_W-1:0] ph;
    logic [uartrx_pkg::DATA_W-1:0]  keep;
    int                             f;
    res    = '0;
    res.ev = uartrx_pkg::EV_NONE;
    if (rx_track.phase == '0) begin
      // Idle: a low line opens a frame at phase 1.
      if (!lvl) begin
        rx_track.phase       = 7'd1;
        rx_track.next_action = uartrx_pkg::START_CHECK_PHASE;
        rx_track.bit_slot    = '0;
      end
    end else begin
      ph = rx_track.phase + 7'd1;
      rx_track.phase = ph;
      if (rx_track.next_action > ph) begin
        // between action points the line is ignored
      end else if (ph <= uartrx_pkg::START_CHECK_PHASE) begin
        if (lvl) begin
          drop_frame();
          res.ev = uartrx_pkg::EV_START_BAD;
        end else begin
          rx_track.next_action = uartrx_pkg::FIRST_SAMPLE_PHASE;
          rx_track.bits        = '0;
        end
      end else if (ph < uartrx_pkg::STOP_PHASE) begin
        if (rx_track.bit_slot < uartrx_pkg::DATA_BITS)
          rx_track.bits[rx_track.bit_slot[2:0]] = lvl;
        rx_track.bit_slot    = rx_track.bit_slot + 4'd1;
        rx_track.next_action = rx_track.next_action + uartrx_pkg::SAMPLE_SPACING;
      end else if (!lvl) begin
        drop_frame();
        res.ev = uartrx_pkg::EV_STOP_BAD;
      end else begin
        // Bits never sampled read as zero.
        keep = (rx_track.bit_slot >= uartrx_pkg::DATA_BITS) ? 8'hFF :
               (8'd1 << rx_track.bit_slot) - 8'd1;
        res.data        = rx_track.bits & keep;
        res.write_index = rx_track.head;
        rx_track.head   = rx_track.head + 9'd1;
        if (rx_track.head == uartrx_pkg::INDEX_W'(DEPTH)) rx_track.head = '0;
        // Fill is taken wide and cut to 9 bits, so a read index past the depth wraps.
        if (rx_track.head >= rd) f = int'(rx_track.head) - int'(rd);
        else f = int'(rx_track.head) + DEPTH - int'(rd);
        rx_track.fill = f[uartrx_pkg::INDEX_W-1:0];
        if (rx_track.fill >= rx_track.high_water) rx_track.high_water = rx_track.fill;
        res.ev = uartrx_pkg::EV_STORED;
        drop_frame();
      end
    end
    res.fill       = rx_track.fill;
    res.high_water = rx_track.high_water;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) $display("tb_top: MISMATCH %s", what);
  endtask

  // Offer one tick, hold it until taken, then queue what it must produce.
  task automatic drive_tick(input logic lvl, input logic [uartrx_pkg::INDEX_W-1:0] rd,
                            input bit pinned, input uartrx_pkg::rx_result_t pin);
    uartrx_pkg::rx_result_t want;
    int                     gap;
    gap = gap_len();
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    line_level   <= lvl;
    read_index   <= rd;
    do @(posedge clk); while (sample_stall);
    want = next_tick_result(lvl, rd);
    if (pinned) want = pin;
    tick_results_q.push_back(want);
    ev_tally[int'(want.ev)]++;
    ticks_sent++;
  endtask

  // Expand one row into line ticks. With scramble set, glitch the line between
  // sample points and wander the read index on every tick but the deciding one.
  task automatic send_frame(input frame_row_t row, input bit scramble);
    int                             span;
    logic                           lvl;
    logic [uartrx_pkg::INDEX_W-1:0] rd;
    bit                             last;
    bit                             on_sample;
    case (row.kind)
      FR_GOOD, FR_STOP_BAD: span = int'(uartrx_pkg::STOP_PHASE);
      FR_START_BAD:         span = int'(uartrx_pkg::START_CHECK_PHASE);
      default:              span = row.len;
    endcase
    for (int p = 1; p <= span; p++) begin
      last = (p == span);
      case (row.kind)
        FR_IDLE:      lvl = 1'b1;
        FR_NOISE:     lvl = 1'($urandom_range(0, 1));
        FR_START_BAD: lvl = last ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
        default: begin
          if (p < BIT_EDGE) lvl = 1'b0;
          else if (p < STOP_EDGE) lvl = row.data[(p - BIT_EDGE) / 10];
          else lvl = (row.kind == FR_GOOD);
        end
      endcase
      on_sample = (p == int'(uartrx_pkg::START_CHECK_PHASE)) ||
                  (p >= int'(uartrx_pkg::STOP_PHASE)) ||
                  (p >= int'(uartrx_pkg::FIRST_SAMPLE_PHASE) &&
                   (p - int'(uartrx_pkg::FIRST_SAMPLE_PHASE)) %
                   int'(uartrx_pkg::SAMPLE_SPACING) == 0);
      if (scramble && (row.kind == FR_GOOD || row.kind == FR_STOP_BAD) && p > 1 &&
          !on_sample && $urandom_range(0, 24) == 0) lvl = ~lvl;
      rd = (scramble && !last) ? uartrx_pkg::INDEX_W'($urandom_range(0, 511)) : row.rd;
      drive_tick(lvl, rd, row.pinned && last, row.pin);
    end
  endtask

  // Hold the sample side until every queued result has come back.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  // Result side: stall at random, in bursts of the same shape as sender gaps.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      result_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  // Check every result item taken against the oldest queued expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (tick_results_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: ev=%0d data=%02h widx=%0d",
                                event_code, data_byte, write_index));
      end else begin
        got_want = tick_results_q.pop_front();
        if (event_code !== got_want.ev || data_byte !== got_want.data ||
            write_index !== got_want.write_index || fill_count !== got_want.fill ||
            high_water !== got_want.high_water)
          flag_mismatch($sformatf(
            "got/want ev %0d/%0d data %02h/%02h widx %0d/%0d fill %0d/%0d hw %0d/%0d",
            event_code, got_want.ev, data_byte, got_want.data,
            write_index, got_want.write_index, fill_count, got_want.fill,
            high_water, got_want.high_water));
      end
    end
  end

  // Watchdog: give up on a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timed out after %0d cycles, %0d results pending",
               cycle_count, tick_results_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    frame_row_t row;
    int         pick;
    bit         paused;
    paused = 1'b0;

    // Hold reset at the start, then release it once for the whole run.
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: extremes of data and read index, each event code.
    foreach (directed_rows[i]) send_frame(directed_rows[i], 1'b0);
    directed_ticks = ticks_sent;
    drain_results();

    // Random part: mostly clean frames with random bytes, the rest rejects,
    // idle stretches and raw line noise that can land mid-frame.
    while (ticks_sent - directed_ticks < RANDOM_TICKS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (!paused && ticks_sent - directed_ticks > RANDOM_TICKS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      pick       = $urandom_range(0, 99);
      row        = directed_rows[0];
      row.pinned = 1'b0;
      row.data   = uartrx_pkg::DATA_W'($urandom_range(0, 255));
      row.rd     = uartrx_pkg::INDEX_W'($urandom_range(0, 511));
      row.len    = 0;
      if (pick < 70) row.kind = FR_GOOD;
      else if (pick < 80) row.kind = FR_STOP_BAD;
      else if (pick < 90) row.kind = FR_START_BAD;
      else if (pick < 95) begin
        row.kind = FR_IDLE;
        row.len  = $urandom_range(1, 20);
      end else begin
        row.kind = FR_NOISE;
        row.len  = $urandom_range(1, 30);
      end
      send_frame(row, 1'b1);
    end

    // Let the pipeline empty, then keep the clock running to catch stray results.
    calm = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d ticks (%0d directed), %0d stored, %0d start rejects, %0d stop rejects",
             ticks_sent, directed_ticks, ev_tally[int'(uartrx_pkg::EV_STORED)],
             ev_tally[int'(uartrx_pkg::EV_START_BAD)],
             ev_tally[int'(uartrx_pkg::EV_STOP_BAD)]);
    $display("tb_top: ring head at %0d, high-water %0d, %0d mismatches",
             rx_track.head, rx_track.high_water, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/uartrx_pkg.sv
rtl/core/uartrx_step.sv
rtl/core/uart_rx_tick_sampler_ring_writer.sv
tb/tb_top.sv
